// ===== sv/mmwd_pkg.sv =====
// Shared types and codes for the multi-module watchdog table.
// Used by mmwd_cell and multi_module_watchdog_table; depends on nothing.
package mmwd_pkg;

    localparam logic [2:0] OP_REG    = 3'd0;
    localparam logic [2:0] OP_UNREG  = 3'd1;
    localparam logic [2:0] OP_HB     = 3'd2;
    localparam logic [2:0] OP_CHECK  = 3'd3;
    localparam logic [2:0] OP_MANUAL = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_DUP       = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    localparam logic [2:0] ACT_NONE = 3'd5;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_EVENT  = 1'b1;

    // broadcast copy of the item under work
    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] id;
        logic [47:0] tmo;
        logic [2:0]  action;
        logic [47:0] now;
    } req_t;

    // scan token walking down the row of cells
    typedef struct packed {
        logic vld;
        logic done;
        logic dup;
        logic saw_free;
    } tok_t;

    typedef struct packed {
        logic        vld;
        logic [31:0] id;
        logic [47:0] elapsed;
        logic [2:0]  action;
    } ev_t;

endpackage

// ===== sv/mmwd_cell.sv =====
// One table entry of the watchdog row plus its slot of the scan token.
// Depends on mmwd_pkg.
module mmwd_cell import mmwd_pkg::*; #(
    parameter int TIME_BITS = 48
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic hold,
    input  req_t req,
    input  tok_t tok_in,
    output tok_t tok_out,
    output ev_t  ev
);

    localparam logic [63:0] TMASK = (TIME_BITS >= 64) ? {64{1'b1}} :
                                    ((64'd1 << TIME_BITS) - 64'd1);

    tok_t        tok_reg;
    logic        used_reg;
    logic        act_reg;
    logic [31:0] id_reg;
    logic [47:0] tmo_reg;
    logic [47:0] stamp_reg;
    logic [2:0]  action_reg;

    logic        match;
    logic [63:0] elapsed;
    logic        fire;
    logic        alloc;
    logic        unreg_hit;
    logic        hb_hit;

    always_comb begin
        match     = used_reg && (id_reg == req.id);
        elapsed   = ({16'd0, req.now} - {16'd0, stamp_reg}) & TMASK;
        fire      = tok_reg.vld && (req.op == OP_CHECK) && act_reg &&
                    (elapsed > {16'd0, tmo_reg});
        alloc     = tok_reg.vld && (req.op == OP_REG) && !used_reg &&
                    !tok_reg.saw_free && !tok_reg.dup;
        unreg_hit = tok_reg.vld && (req.op == OP_UNREG) && !tok_reg.done && match;
        hb_hit    = tok_reg.vld && (req.op == OP_HB) && !tok_reg.done && match && act_reg;

        tok_out = tok_reg;
        case (req.op)
            OP_REG: begin
                if (match) tok_out.dup = 1'b1;
                if (!used_reg) tok_out.saw_free = 1'b1;
            end
            OP_UNREG: if (match) tok_out.done = 1'b1;
            OP_HB: if (match && act_reg) tok_out.done = 1'b1;
            default: ;
        endcase

        ev.vld     = fire;
        ev.id      = id_reg;
        ev.elapsed = elapsed[47:0];
        ev.action  = action_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.vld <= 1'b0;
            used_reg    <= 1'b0;
            act_reg     <= 1'b0;
        end else if (!hold) begin
            tok_reg <= tok_in;
            if (alloc) begin
                used_reg <= 1'b1;
                act_reg  <= 1'b1;
            end
            if (unreg_hit) act_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!hold) begin
            if (alloc) begin
                id_reg     <= req.id;
                tmo_reg    <= req.tmo;
                action_reg <= req.action;
            end
            if (alloc || hb_hit || fire) stamp_reg <= req.now;
        end
    end

endmodule

// ===== sv/multi_module_watchdog_table.sv =====
// Top level of the multi-module watchdog table: item register, row of
// mmwd_cell entries, event collection and result register. Depends on mmwd_pkg.
//
//  channel | ports                        | carries
//  --------+------------------------------+-----------------------------------
//  input   | s_tvalid s_tready s_tdata    | one operation with its time stamp
//  result  | m_tvalid m_tready m_tdata    | status or timeout event
//          | m_tuser m_tlast              | kind, last result of the item
//
// Register, unregister, heartbeat and check walk a token through the
// MAX_MODULES cells, one cell a cycle while the row is not stalled on
// m_tready. Manual trigger sends no token, and undefined operations are
// taken without a result. Reset clears every active mark, the fill of the
// row and the trigger total at once; no clearing pass is needed.
module multi_module_watchdog_table import mmwd_pkg::*; #(
    parameter int MAX_MODULES = 64,
    parameter int TIME_BITS   = 48
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // operation[2:0] mod_id[34:3] tmo_ms[82:35] action[85:83]
    // now_ms[133:86], zero fill above
    input  logic [135:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[1:0] event_module[33:2] elapsed_ms[81:34] event_action[84:82]
    // trigger_total[116:85], zero fill above
    output logic [119:0] m_tdata,
    // kind[0]
    output logic [0:0]   m_tuser,
    output logic         m_tlast
);

    localparam logic [63:0] TMASK = (TIME_BITS >= 64) ? {64{1'b1}} :
                                    ((64'd1 << TIME_BITS) - 64'd1);

    // item under work and control
    logic        busy_reg;
    req_t        req_reg;
    tok_t        end_reg;
    logic [31:0] trig_reg;

    // newest timeout event, held back until we know whether it is the last
    logic        pend_vld_reg;
    ev_t         pend_reg;
    logic [31:0] pend_total_reg;

    // result register
    logic         m_valid_reg;
    logic [119:0] m_data_reg;
    logic         m_kind_reg;
    logic         m_last_reg;

    tok_t tok_w [MAX_MODULES+1];
    ev_t  ev_w  [MAX_MODULES];
    ev_t  ev_any;
    logic hold;
    logic out_free;
    logic out_load;
    logic accept;
    req_t in_req;
    logic [1:0] fin_status;

    assign s_tready = !busy_reg;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        in_req.op     = s_tdata[2:0];
        in_req.id     = s_tdata[34:3];
        in_req.tmo    = s_tdata[82:35];
        in_req.action = s_tdata[85:83];
        in_req.now    = s_tdata[133:86] & TMASK[47:0];
    end

    // inject the scan token into the first cell
    always_comb begin
        tok_w[0].vld      = accept && (in_req.op <= OP_CHECK);
        tok_w[0].done     = 1'b0;
        tok_w[0].dup      = 1'b0;
        tok_w[0].saw_free = 1'b0;
    end

    genvar g;
    generate
        for (g = 0; g < MAX_MODULES; g++) begin : g_row
            mmwd_cell #(.TIME_BITS(TIME_BITS)) u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .hold    (hold),
                .req     (req_reg),
                .tok_in  (tok_w[g]),
                .tok_out (tok_w[g+1]),
                .ev      (ev_w[g])
            );
        end
    endgenerate

    // only the cell holding the token can fire, so an OR gathers the event
    always_comb begin
        ev_any = '0;
        for (int i = 0; i < MAX_MODULES; i++) begin
            if (ev_w[i].vld) ev_any = ev_any | ev_w[i];
        end
    end

    // stall the row while a result cannot move on
    assign hold = (ev_any.vld && pend_vld_reg && !out_free) ||
                  (end_reg.vld && !out_free);

    // load the result register: flush of a held event or the final result
    assign out_load = !accept && !hold &&
                      ((ev_any.vld && pend_vld_reg) || end_reg.vld);

    always_comb begin
        case (req_reg.op)
            OP_REG: begin
                if (!end_reg.saw_free) fin_status = ST_FULL;
                else if (end_reg.dup)  fin_status = ST_DUP;
                else                   fin_status = ST_OK;
            end
            OP_UNREG, OP_HB: fin_status = end_reg.done ? ST_OK : ST_NOT_FOUND;
            default:         fin_status = ST_OK;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            end_reg.vld  <= 1'b0;
            pend_vld_reg <= 1'b0;
            trig_reg     <= 32'd0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (out_load) m_valid_reg <= 1'b1;
            else if (m_tready) m_valid_reg <= 1'b0;
            if (accept) begin
                if (in_req.op <= OP_MANUAL) busy_reg <= 1'b1;
                if (in_req.op == OP_MANUAL) begin
                    pend_vld_reg <= 1'b1;
                    trig_reg     <= trig_reg + 32'd1;
                    end_reg.vld  <= 1'b1;
                end
            end else if (!hold) begin
                end_reg <= tok_w[MAX_MODULES];
                if (ev_any.vld) begin
                    // flush the held event, keep the new one
                    pend_vld_reg <= 1'b1;
                    trig_reg     <= trig_reg + 32'd1;
                end
                if (end_reg.vld) begin
                    pend_vld_reg <= 1'b0;
                    busy_reg     <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg <= in_req;
            if (in_req.op == OP_MANUAL) begin
                pend_reg.id      <= in_req.id;
                pend_reg.elapsed <= 48'd0;
                pend_reg.action  <= ACT_NONE;
                pend_total_reg   <= trig_reg + 32'd1;
            end
        end else if (!hold) begin
            if (ev_any.vld) begin
                pend_reg       <= ev_any;
                pend_total_reg <= trig_reg + 32'd1;
                if (pend_vld_reg) begin
                    m_data_reg <= {3'd0, pend_total_reg, pend_reg.action,
                                   pend_reg.elapsed, pend_reg.id, ST_OK};
                    m_kind_reg <= KIND_EVENT;
                    m_last_reg <= 1'b0;
                end
            end
            if (end_reg.vld) begin
                m_last_reg <= 1'b1;
                if (pend_vld_reg) begin
                    m_data_reg <= {3'd0, pend_total_reg, pend_reg.action,
                                   pend_reg.elapsed, pend_reg.id, ST_OK};
                    m_kind_reg <= KIND_EVENT;
                end else begin
                    m_data_reg <= {3'd0, trig_reg, ACT_NONE, 48'd0,
                                   req_reg.id, fin_status};
                    m_kind_reg <= KIND_STATUS;
                end
            end
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_kind_reg;
    assign m_tlast    = m_last_reg;

endmodule
